// ===== src/ptib_pkg.sv =====
package ptib_pkg;

	localparam int NODE_COUNT  = 4096;
	localparam int TETRA_COUNT = 4096;
	localparam int NAW         = $clog2(NODE_COUNT);
	localparam int TAW         = $clog2(TETRA_COUNT);
	localparam int IW          = 12;
	localparam int CW          = 32;
	localparam int EW          = CW + 1;
	localparam int MW          = EW + 1;
	localparam int PW          = 2 * MW;
	localparam int BW          = 2 * EW;
	localparam int DW          = 104;
	localparam int RW          = DW + 1;
	localparam int FRAC        = 28;
	localparam int QW          = CW + 1;
	localparam int TW          = 28;
	localparam int TOL_RESET   = 27;
	localparam int IN_DW       = 160;
	localparam int OUT_DW      = 4 * CW;

	typedef enum logic [1:0] {
		ACT_NODE  = 2'd0,
		ACT_TETRA = 2'd1,
		ACT_QUERY = 2'd2
	} action_t;

	typedef logic [CW-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct packed {
		point_t [3:0] vtx;
		point_t       pt;
	} job_t;

	typedef struct packed {
		logic [2:0] push;
		logic       ready;
	} qctl_t;

	// component picks of one cofactor term: a[ra] * b[rb] * c[rc]
	typedef struct packed {
		logic [1:0] ra;
		logic [1:0] rb;
		logic [1:0] rc;
		logic       neg;
	} term_t;

	function automatic term_t term_of(input logic [2:0] t);
		term_t r;
		case (t)
			3'd0:    r = '{ra: 2'd0, rb: 2'd1, rc: 2'd2, neg: 1'b0};
			3'd1:    r = '{ra: 2'd0, rb: 2'd2, rc: 2'd1, neg: 1'b1};
			3'd2:    r = '{ra: 2'd1, rb: 2'd0, rc: 2'd2, neg: 1'b1};
			3'd3:    r = '{ra: 2'd1, rb: 2'd2, rc: 2'd0, neg: 1'b0};
			3'd4:    r = '{ra: 2'd2, rb: 2'd0, rc: 2'd1, neg: 1'b0};
			3'd5:    r = '{ra: 2'd2, rb: 2'd1, rc: 2'd0, neg: 1'b1};
			default: r = '{ra: 2'd0, rb: 2'd0, rc: 2'd0, neg: 1'b0};
		endcase
		return r;
	endfunction

	function automatic coord_t comp_of(input point_t p, input logic [1:0] c);
		coord_t r;
		case (c)
			2'd0:    r = p.x;
			2'd1:    r = p.y;
			2'd2:    r = p.z;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/ptib_ram.sv =====
module ptib_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/ptib_front.sv =====
module ptib_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// index, coord_x, coord_y, coord_z, vertex_0..vertex_3, zero pad
	input  logic [ptib_pkg::IN_DW-1:0] s_tdata,
	// action
	input  logic [1:0]                 s_tuser,
	output logic                       job_valid,
	input  logic                       job_ready,
	output ptib_pkg::job_t             job_data
);
	import ptib_pkg::*;

	typedef enum logic [1:0] {F_IDLE, F_TET, F_FETCH, F_PUSH} fstate_t;

	fstate_t            state_q;
	logic [2:0]         cnt_q;
	logic [3:0][IW-1:0] vert_q;
	point_t [3:0]       vtx_q;
	point_t             pt_q;

	logic               accept;
	action_t            act;
	logic [IW-1:0]      idx;
	point_t             pin;
	logic [4*IW-1:0]    tet_rdata;
	logic [3*CW-1:0]    node_rdata;
	logic [NAW-1:0]     node_raddr;

	assign s_tready = (state_q == F_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign act      = action_t'(s_tuser);
	assign idx      = s_tdata[IW-1:0];
	assign pin.x    = s_tdata[IW +: CW];
	assign pin.y    = s_tdata[IW+CW +: CW];
	assign pin.z    = s_tdata[IW+2*CW +: CW];

	always_comb begin
		case (state_q)
			F_TET:   node_raddr = tet_rdata[NAW-1:0];
			F_FETCH: node_raddr = vert_q[cnt_q[1:0]][NAW-1:0];
			default: node_raddr = '0;
		endcase
	end

	ptib_ram #(.WIDTH(4*IW), .DEPTH(TETRA_COUNT)) u_tet_ram (
		.clk   (clk),
		.we    (accept && act == ACT_TETRA),
		.waddr (idx[TAW-1:0]),
		.wdata (s_tdata[IW+3*CW +: 4*IW]),
		.raddr (idx[TAW-1:0]),
		.rdata (tet_rdata)
	);

	ptib_ram #(.WIDTH(3*CW), .DEPTH(NODE_COUNT)) u_node_ram (
		.clk   (clk),
		.we    (accept && act == ACT_NODE),
		.waddr (idx[NAW-1:0]),
		.wdata (pin),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept && act == ACT_QUERY) begin
						state_q <= F_TET;
					end
				end
				F_TET: begin
					cnt_q   <= 3'd1;
					state_q <= F_FETCH;
				end
				F_FETCH: begin
					if (cnt_q == 3'd4) begin
						state_q <= F_PUSH;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				F_PUSH: begin
					if (job_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pt_q <= pin;
		end
		if (state_q == F_TET) begin
			vert_q <= tet_rdata;
		end
		if (state_q == F_FETCH) begin
			vtx_q[cnt_q[1:0] - 2'd1] <= node_rdata;
		end
	end

	assign job_valid    = (state_q == F_PUSH);
	assign job_data.vtx = vtx_q;
	assign job_data.pt  = pt_q;

endmodule

// ===== src/ptib_fifo.sv =====
module ptib_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ptib_pkg::job_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output ptib_pkg::job_t out_data
);
	import ptib_pkg::*;

	job_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_data;
		end
	end

endmodule

// ===== src/ptib_back.sv =====
module ptib_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	output logic                        job_ready,
	input  ptib_pkg::job_t              job_data,
	input  logic [ptib_pkg::TW-1:0]     tol,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// weight_0, weight_1, weight_2, weight_3
	output logic [ptib_pkg::OUT_DW-1:0] m_tdata,
	// inside_res, degenerate
	output logic [1:0]                  m_tuser
);
	import ptib_pkg::*;

	typedef enum logic [2:0] {B_IDLE, B_MUL, B_PREP, B_DIV, B_FIN} bstate_t;

	bstate_t              state_q;
	logic [1:0]           m_q;
	logic [2:0]           t_q;
	logic [2:0]           ph_q;
	logic [4:0]           dcnt_q;
	logic                 out_valid_q;

	logic signed [EW-1:0] row_q [4][3];
	logic signed [EW-1:0] opr_q;
	logic signed [BW-1:0] bc_q;
	logic signed [PW-1:0] mres_q;
	logic signed [DW-1:0] acc_q;
	logic signed [DW-1:0] det_q [4];
	logic [RW-1:0]        dmag_q;
	logic [RW-1:0]        rem_q [4];
	logic [CW-1:0]        quo_q [4];
	logic [3:0]           nlo_q [4];
	logic [3:0]           neg_q;
	logic [3:0]           big_q;
	logic                 degen_q;
	logic [OUT_DW-1:0]    res_data_q;
	logic [1:0]           res_user_q;

	term_t                term;
	logic [1:0]           slot;
	logic [1:0]           row_sel;
	logic [1:0]           comp_sel;
	logic signed [EW-1:0] elem;
	logic signed [MW-1:0] mul_a;
	logic signed [MW-1:0] mul_b;
	logic signed [PW-1:0] prod;
	logic signed [DW-1:0] addend;
	logic signed [DW-1:0] acc_nx;
	logic signed [EW-1:0] ld [4][3];
	logic signed [DW-1:0] num [4];
	logic [DW-1:0]        absn [4];
	logic [DW-1:0]        absd;
	logic [3:0]           pneg;
	logic [3:0]           pbig;
	logic [RW-1:0]        shf [4];
	logic [RW-1:0]        rem_nx [4];
	logic [3:0]           qbit;
	logic                 dbit [4];
	logic [QW-1:0]        qr;
	logic [QW-1:0]        lim;
	logic [QW-1:0]        mag;
	logic [OUT_DW-1:0]    fin_data;
	logic                 fin_inside;
	logic                 out_free;

	assign job_ready = (state_q == B_IDLE);
	assign out_free  = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = res_data_q;
	assign m_tuser   = res_user_q;

	// edge vectors from V0, point offset in row 3
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int c = 0; c < 3; c++) begin
				ld[k][c] = EW'(signed'(comp_of(job_data.vtx[k+1], 2'(c))))
					- EW'(signed'(comp_of(job_data.vtx[0], 2'(c))));
			end
		end
		for (int c = 0; c < 3; c++) begin
			ld[3][c] = EW'(signed'(comp_of(job_data.pt, 2'(c))))
				- EW'(signed'(comp_of(job_data.vtx[0], 2'(c))));
		end
	end

	// one operand read per cycle: b, c, a, a
	always_comb begin
		term = term_of(t_q);
		case (ph_q)
			3'd0:    slot = 2'd1;
			3'd1:    slot = 2'd2;
			default: slot = 2'd0;
		endcase
		case (slot)
			2'd1:    comp_sel = term.rb;
			2'd2:    comp_sel = term.rc;
			default: comp_sel = term.ra;
		endcase
		row_sel = (m_q != 2'd0 && slot == m_q - 2'd1) ? 2'd3 : slot;
		elem    = row_q[row_sel][comp_sel];
	end

	always_comb begin
		case (ph_q)
			3'd1: begin
				mul_a = MW'(opr_q);
				mul_b = MW'(elem);
			end
			3'd2: begin
				mul_a = MW'(elem);
				mul_b = MW'(signed'(bc_q[BW-1:EW]));
			end
			default: begin
				mul_a = MW'(elem);
				mul_b = {1'b0, bc_q[EW-1:0]};
			end
		endcase
		prod   = mul_a * mul_b;
		addend = (ph_q == 3'd3) ? (DW'(mres_q) <<< EW) : DW'(mres_q);
		acc_nx = term.neg ? acc_q - addend : acc_q + addend;
	end

	// numerators, magnitudes, saturation test
	always_comb begin
		num[0] = det_q[0] - det_q[1] - det_q[2] - det_q[3];
		for (int k = 1; k < 4; k++) num[k] = det_q[k];
		absd = det_q[0][DW-1] ? DW'(-det_q[0]) : DW'(det_q[0]);
		for (int k = 0; k < 4; k++) begin
			absn[k] = num[k][DW-1] ? DW'(-num[k]) : DW'(num[k]);
			pneg[k] = num[k][DW-1] != det_q[0][DW-1];
			pbig[k] = {4'b0, absn[k]} >= {absd, 4'b0};
		end
	end

	// restoring division step, four lanes
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			dbit[k]   = (dcnt_q[4:2] == 3'b111) ? nlo_q[k][dcnt_q[1:0]] : 1'b0;
			shf[k]    = {rem_q[k][RW-2:0], dbit[k]};
			qbit[k]   = shf[k] >= dmag_q;
			rem_nx[k] = qbit[k] ? shf[k] - dmag_q : shf[k];
		end
	end

	// round, saturate, snap
	always_comb begin
		fin_data   = '0;
		fin_inside = !degen_q;
		qr         = '0;
		lim        = '0;
		mag        = '0;
		for (int k = 0; k < 4; k++) begin
			qr  = {1'b0, quo_q[k]} + QW'({rem_q[k], 1'b0} >= {1'b0, dmag_q});
			lim = neg_q[k] ? QW'(33'h080000000) : QW'(33'h07fffffff);
			mag = (big_q[k] || qr > lim) ? lim : qr;
			if (mag < {5'b0, tol}) mag = '0;
			if (degen_q) mag = '0;
			fin_data[k*CW +: CW] = neg_q[k] ? CW'(-mag) : mag[CW-1:0];
			if (neg_q[k] && mag != '0) fin_inside = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			m_q         <= '0;
			t_q         <= '0;
			ph_q        <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
			res_data_q  <= '0;
			res_user_q  <= '0;
		end else begin
			if (state_q == B_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						m_q     <= '0;
						t_q     <= '0;
						ph_q    <= '0;
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					if (ph_q == 3'd4) begin
						ph_q <= '0;
						if (t_q == 3'd5) begin
							t_q <= '0;
							if (m_q == 2'd3) begin
								state_q <= B_PREP;
							end else begin
								m_q <= m_q + 2'd1;
							end
						end else begin
							t_q <= t_q + 3'd1;
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				B_PREP: begin
					dcnt_q  <= 5'd31;
					state_q <= (det_q[0] == '0) ? B_FIN : B_DIV;
				end
				B_DIV: begin
					if (dcnt_q == 5'd0) begin
						state_q <= B_FIN;
					end else begin
						dcnt_q <= dcnt_q - 5'd1;
					end
				end
				B_FIN: begin
					if (out_free) begin
						res_data_q  <= fin_data;
						res_user_q  <= {degen_q, fin_inside};
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				row_q <= ld;
				acc_q <= '0;
			end
			B_MUL: begin
				case (ph_q)
					3'd0: opr_q <= elem;
					3'd1: bc_q  <= BW'(prod);
					3'd2: mres_q <= prod;
					3'd3: begin
						acc_q  <= acc_nx;
						mres_q <= prod;
					end
					default: begin
						if (t_q == 3'd5) begin
							det_q[m_q] <= acc_nx;
							acc_q      <= '0;
						end else begin
							acc_q <= acc_nx;
						end
					end
				endcase
			end
			B_PREP: begin
				degen_q <= (det_q[0] == '0);
				dmag_q  <= RW'(absd);
				neg_q   <= pneg;
				big_q   <= pbig;
				for (int k = 0; k < 4; k++) begin
					rem_q[k] <= RW'(absn[k] >> 4);
					nlo_q[k] <= absn[k][3:0];
					quo_q[k] <= '0;
				end
			end
			B_DIV: begin
				for (int k = 0; k < 4; k++) begin
					rem_q[k] <= rem_nx[k];
					quo_q[k] <= {quo_q[k][CW-2:0], qbit[k]};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== src/point_in_tetrahedron_barycentric_unit.sv =====
// Writes of nodes and tetrahedra are taken one per cycle while no query holds the input.
// A query holds the input while its tetrahedron and vertices are fetched and its job is queued.
// Back end: four determinants on one shared 34x34 multiplier, one cofactor term at a time,
// then the four-lane divider, which is skipped if degenerate.
// The back end takes a new query only once the last result is registered; a 2-entry queue
// and an output register decouple the sides.
// Reset clears control state and sets zero_tolerance to 27; tables are not cleared.
module point_in_tetrahedron_barycentric_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// index, coord_x, coord_y, coord_z, vertex_0..vertex_3, zero pad
	input  logic [ptib_pkg::IN_DW-1:0]  s_tdata,
	// action
	input  logic [1:0]                  s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// weight_0, weight_1, weight_2, weight_3
	output logic [ptib_pkg::OUT_DW-1:0] m_tdata,
	// inside_res, degenerate
	output logic [1:0]                  m_tuser,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ptib_pkg::TW-1:0]     cfg_data
);
	import ptib_pkg::*;

	logic [TW-1:0] tol_q;
	logic          fq_valid;
	logic          fq_ready;
	job_t          fq_data;
	logic          bq_valid;
	logic          bq_ready;
	job_t          bq_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TW'(TOL_RESET);
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	ptib_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job_data  (fq_data)
	);

	ptib_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_data),
		.out_valid (bq_valid),
		.out_ready (bq_ready),
		.out_data  (bq_data)
	);

	ptib_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bq_valid),
		.job_ready (bq_ready),
		.job_data  (bq_data),
		.tol       (tol_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == '0 && !m_tuser[0])
		else $error("degenerate result with nonzero weights or inside set");

	a_inside_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			!m_tdata[CW-1] && !m_tdata[2*CW-1] && !m_tdata[3*CW-1] && !m_tdata[4*CW-1])
		else $error("inside flagged with a negative weight");

	a_query_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_QUERY |=> !s_tready)
		else $error("input taken during vertex fetch");

endmodule
